FILE: design/aes_pkg.sv
package aes_pkg;

    localparam int COUNT_BITS = 16;
    localparam int CMP_W      = (COUNT_BITS + 1 > 16) ? COUNT_BITS + 1 : 16;

    localparam logic [7:0] CH_ESC      = 8'h1b;
    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_DEL      = 8'h7f;
    localparam logic [7:0] CH_FINAL_LO = 8'h40;
    localparam logic [7:0] CH_FINAL_HI = 8'h7e;
    localparam logic [7:0] CH_CSI_OPEN = 8'h5b;
    localparam logic [7:0] CH_OSC_OPEN = 8'h5d;
    localparam logic [7:0] CH_BSLASH   = 8'h5c;

    localparam logic [15:0] CAPACITY_RESET = 16'd1024;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic        keep;
        logic [15:0] kept_total;
    } aes_result_t;

endpackage

FILE: design/aes_if.sv
interface aes_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, in_byte, in_last, input ready);
    modport sink   (input valid, in_byte, in_last, output ready);
endinterface

interface aes_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_keep;
    logic        out_last;
    logic [15:0] kept_total;

    modport source (output valid, out_byte, out_keep, out_last, kept_total, input ready);
    modport sink   (input valid, out_byte, out_keep, out_last, kept_total, output ready);
endinterface

FILE: design/ansi_escape_stripper.sv
// ANSI escape stripper: takes one byte word per cycle unless stalled and returns one result
// word per input via an input register, then a result register. Both sides may stall freely;
// with output ready held high a word is taken every cycle. capacity_reg resets to 1024 and is
// written via cfg_we/cfg_wdata, by the user only while the block is idle (not enforced). At
// most capacity-1 bytes are kept per line; state and count clear after the line's last word.
module ansi_escape_stripper
    import aes_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_wdata,
    aes_in_if.sink           in_ch,
    aes_out_if.source        out_ch
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic [15:0] capacity_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_keep_reg;
    logic        out_last_reg;
    logic [15:0] kept_total_reg;
    logic        advance;
    aes_result_t result;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    aes_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .in_byte  (s1_byte_reg),
        .in_last  (s1_last_reg),
        .capacity (capacity_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAPACITY_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_last_reg <= in_ch.in_last;
        end
        if (advance)
        begin
            out_byte_reg   <= result.keep ? s1_byte_reg : 8'h00;
            out_keep_reg   <= result.keep;
            out_last_reg   <= s1_last_reg;
            kept_total_reg <= result.kept_total;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.out_keep   = out_keep_reg;
    assign out_ch.out_last   = out_last_reg;
    assign out_ch.kept_total = kept_total_reg;

    a_keep_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.out_keep |->
            out_ch.out_byte >= CH_SPACE && out_ch.out_byte != CH_DEL
            && out_ch.kept_total != 16'd0)
        else $error("kept word is not printable or count is zero");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.out_keep |-> out_ch.out_byte == 8'h00)
        else $error("dropped word carries data");

endmodule

FILE: design/aes_parser.sv
module aes_parser
    import aes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic [15:0] capacity,
    output aes_result_t result
);

    localparam logic [2:0] MODE_NORMAL  = 3'd0;
    localparam logic [2:0] MODE_ESC     = 3'd1;
    localparam logic [2:0] MODE_CSI     = 3'd2;
    localparam logic [2:0] MODE_OSC     = 3'd3;
    localparam logic [2:0] MODE_OSC_ESC = 3'd4;

    logic [2:0]       mode_reg;
    logic [2:0]       mode_next;
    count_t           count_reg;
    count_t           count_next;
    logic             keep;
    logic             printable;
    logic             room;
    logic [CMP_W-1:0] count_inc;
    logic [CMP_W-1:0] count_ext;

    assign printable = (in_byte >= CH_SPACE) && (in_byte != CH_DEL);
    assign count_inc = CMP_W'(count_reg) + CMP_W'(1);
    assign room      = (count_reg != '1) && (count_inc < CMP_W'(capacity));

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        keep       = 1'b0;
        unique case (mode_reg)
            MODE_ESC:
            begin
                if (in_byte == CH_CSI_OPEN)
                    mode_next = MODE_CSI;
                else if (in_byte == CH_OSC_OPEN)
                    mode_next = MODE_OSC;
                else
                    mode_next = MODE_NORMAL;
            end
            MODE_CSI:
            begin
                if (in_byte >= CH_FINAL_LO && in_byte <= CH_FINAL_HI)
                    mode_next = MODE_NORMAL;
            end
            MODE_OSC_ESC:
            begin
                if (in_byte == CH_BSLASH || in_byte == CH_BEL)
                    mode_next = MODE_NORMAL;
                else if (in_byte == CH_ESC)
                    mode_next = MODE_OSC_ESC;
                else
                    mode_next = MODE_OSC;
            end
            MODE_OSC:
            begin
                if (in_byte == CH_BEL)
                    mode_next = MODE_NORMAL;
                else if (in_byte == CH_ESC)
                    mode_next = MODE_OSC_ESC;
            end
            default:
            begin
                if (in_byte == CH_ESC)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    if (printable && room)
                    begin
                        count_next = count_inc[COUNT_BITS-1:0];
                        keep       = 1'b1;
                    end
                end
            end
        endcase
    end

    assign count_ext = CMP_W'(count_next);
    assign result    = {keep, count_ext[15:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            count_reg <= '0;
        end
        else if (step)
        begin
            if (in_last)
            begin
                mode_reg  <= MODE_NORMAL;
                count_reg <= '0;
            end
            else
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
        end
    end

    a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_last |=> mode_reg == MODE_NORMAL && count_reg == '0)
        else $error("state not cleared after last word");

    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        step && !in_last |=> count_reg >= $past(count_reg))
        else $error("kept count went down inside a line");

    a_keep_normal: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.keep |-> mode_reg == MODE_NORMAL && printable)
        else $error("word kept outside normal text");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.keep |-> CMP_W'(count_next) < CMP_W'(capacity))
        else $error("kept count reached capacity");

endmodule
